// ----- rtl/apsp_pkg.sv -----
// ----------------------------------------------------------------------------
// apsp_pkg - shared types and constants of the all-pairs shortest path block
// Matrix size, distance width, word layouts and address helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int DIST_WIDTH   = 32;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int NW     = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [DIST_WIDTH-1:0] t_dist;
    typedef logic [VW-1:0]         t_vidx;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [31:0] weight;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [31:0] distance;
    } t_out_word;

    // chain control: shift every cell; tail takes load data instead of head
    typedef struct packed {
        logic shift;
        logic load;
    } t_chain_ctl;

    function automatic t_addr f_addr(t_vidx r, t_vidx c);
        logic [2*ADDR_W-1:0] p;
        p = (2*ADDR_W)'(r) * (2*ADDR_W)'(MAX_VERTICES) + (2*ADDR_W)'(c);
        return p[ADDR_W-1:0];
    endfunction

    function automatic t_dist f_w2d(logic [31:0] w);
        logic [DIST_WIDTH+31:0] t;
        t = {{DIST_WIDTH{1'b0}}, w};
        return t[DIST_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] f_d2o(t_dist d);
        logic [DIST_WIDTH+31:0] t;
        t = {32'd0, d};
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/apsp_cell.sv -----
// ----------------------------------------------------------------------------
// apsp_cell - one cell of the pivot row chain
// Holds one pivot row entry; shifts toward the head, tail wraps or loads.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_cell (
    input  wire logic                 i_clk,
    input  wire apsp_pkg::t_chain_ctl i_ctl,
    input  wire logic                 i_tail,
    input  wire apsp_pkg::t_dist      i_next,
    input  wire apsp_pkg::t_dist      i_head,
    input  wire apsp_pkg::t_dist      i_load,
    output apsp_pkg::t_dist           o_value
);
    import apsp_pkg::*;

    t_dist r_value;
    t_dist n_value;

    always_comb begin
        if (!i_tail) begin
            n_value = i_next;
        end else if (i_ctl.load) begin
            n_value = i_load;
        end else begin
            n_value = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/apsp_dist_mem.sv -----
// ----------------------------------------------------------------------------
// apsp_dist_mem - distance matrix store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_dist_mem (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire apsp_pkg::t_addr i_wr_addr,
    input  wire apsp_pkg::t_dist i_wr_data,
    input  wire apsp_pkg::t_addr i_rd_addr,
    output apsp_pkg::t_dist      o_rd_data
);
    import apsp_pkg::*;

    t_dist r_mem [MAX_VERTICES*MAX_VERTICES];
    t_dist r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/all_pairs_shortest_path.sv -----
// ----------------------------------------------------------------------------
// all_pairs_shortest_path - Floyd-Warshall distance matrix engine
// Stores a square distance matrix and relaxes it in place on command.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid/o_in_ready, i_in_word): write, run or read word.
//  - Output channel (o_out_valid/i_out_ready, o_out_word): read data (kind 0)
//    or a finish marker (kind 1, distance 0). Writes give no output word.
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data): vertex_count, only
//    taken while idle; values above the matrix side act as the full side.
//  - Reads pass the memory read register, then the output register.
//  - Run: per pivot k, row k is loaded into the cell chain, then each row
//    fetches d[i][k] and relaxes its entries, one relaxation per cycle; the
//    single memory read port sets this pace.
//  - A new word is taken when idle and the output register is free or being
//    taken in the same cycle, so a stalled receiver holds the block off.
//  - Reset clears control state and sets vertex_count to 64; matrix contents
//    are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module all_pairs_shortest_path (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire apsp_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output apsp_pkg::t_out_word     o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [6:0]         i_cfg_data
);
    import apsp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_LOAD, S_DIK, S_ROW, S_FIN
    } t_state;

    t_state    r_state;
    t_vidx     r_k, r_i, r_j, r_nm1;
    logic [6:0] r_vc;
    logic      r_ld_v, r_dik_v, r_cmp_v, r_rd_in;
    t_addr     r_cmp_addr;
    t_dist     r_dik;
    t_out_word r_out;
    logic      r_out_v;

    logic      w_accept, w_inside;
    t_vidx     w_row, w_col;
    t_addr     w_rd_addr;
    t_dist     w_rd_data;
    logic      w_wr_en;
    t_addr     w_wr_addr;
    t_dist     w_wr_data;
    logic [DIST_WIDTH:0] w_sum;
    t_dist     w_via;
    logic      w_better;
    logic [NW-1:0] w_n;
    t_chain_ctl w_ctl;
    t_dist     w_cell [MAX_VERTICES];

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_v || i_out_ready);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_row    = VW'(i_in_word.row_index);
    assign w_col    = VW'(i_in_word.col_index);
    assign w_inside = (9'(i_in_word.row_index) < 9'(MAX_VERTICES))
                   && (9'(i_in_word.col_index) < 9'(MAX_VERTICES));

    // oversized vertex count clamps to the full matrix side
    assign w_n = (8'(r_vc) > 8'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_vc);

    always_comb begin
        unique case (r_state)
            S_LOAD:  w_rd_addr = f_addr(r_k, r_j);
            S_DIK:   w_rd_addr = f_addr(r_i, r_k);
            S_ROW:   w_rd_addr = f_addr(r_i, r_j);
            default: w_rd_addr = f_addr(w_row, w_col);
        endcase
    end

    // relaxation: saturating sum through the pivot against the current entry
    assign w_sum    = {1'b0, r_dik} + {1'b0, w_cell[0]};
    assign w_via    = w_sum[DIST_WIDTH] ? '1 : w_sum[DIST_WIDTH-1:0];
    assign w_better = r_cmp_v && (w_via < w_rd_data);

    always_comb begin
        if (w_better) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cmp_addr;
            w_wr_data = w_via;
        end else begin
            w_wr_en   = w_accept && (i_in_word.operation == OP_WRITE) && w_inside;
            w_wr_addr = f_addr(w_row, w_col);
            w_wr_data = f_w2d(i_in_word.weight);
        end
    end

    apsp_dist_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // pivot row chain: loads row k, then rotates once per relaxation
    assign w_ctl = '{shift: (r_ld_v || r_cmp_v), load: r_ld_v};

    for (genvar m = 0; m < MAX_VERTICES; m++) begin : g_cell
        apsp_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_tail  (VW'(m) == r_nm1),
            .i_next  (w_cell[(m + 1) % MAX_VERTICES]),
            .i_head  (w_cell[0]),
            .i_load  (w_rd_data),
            .o_value (w_cell[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vc    <= 7'd64;
            r_ld_v  <= 1'b0;
            r_dik_v <= 1'b0;
            r_cmp_v <= 1'b0;
            r_out_v <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_nm1   <= '0;
        end else begin
            r_ld_v  <= 1'b0;
            r_dik_v <= 1'b0;
            r_cmp_v <= 1'b0;
            if (r_dik_v) begin
                r_dik <= w_rd_data;
            end
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_vc <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_word.operation)
                            OP_RUN: begin
                                r_k   <= '0;
                                r_i   <= '0;
                                r_j   <= '0;
                                r_nm1 <= VW'(w_n - NW'(1));
                                r_state <= (w_n == '0) ? S_FIN : S_LOAD;
                            end
                            OP_READ: begin
                                r_rd_in <= w_inside;
                                r_state <= S_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_out.kind     <= KIND_READ;
                    r_out.distance <= r_rd_in ? f_d2o(w_rd_data) : f_d2o('1);
                    r_out_v        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_LOAD: begin
                    r_ld_v <= 1'b1;
                    if (r_j == r_nm1) begin
                        r_j     <= '0;
                        r_i     <= '0;
                        r_state <= S_DIK;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DIK: begin
                    r_dik_v <= 1'b1;
                    r_j     <= '0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_cmp_v    <= 1'b1;
                    r_cmp_addr <= f_addr(r_i, r_j);
                    if (r_j == r_nm1) begin
                        r_j <= '0;
                        if (r_i == r_nm1) begin
                            r_i <= '0;
                            if (r_k == r_nm1) begin
                                r_state <= S_FIN;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DIK;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_FIN: begin
                    r_out.kind     <= KIND_DONE;
                    r_out.distance <= 32'd0;
                    r_out_v        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_out_v && r_out.kind == KIND_DONE))
        else $error("finish word not presented");

    a_cmp_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> (r_state == S_LOAD || r_state == S_DIK
                     || r_state == S_ROW || r_state == S_FIN))
        else $error("relaxation outside a run");

    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> !w_accept)
        else $error("input word taken during relaxation");

endmodule

`default_nettype wire
